[rtl/core/assert_macros.svh]
// Assertion macros shared by the priority bin queue tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define PBQ_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pbq assertion failed");

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define PBQ_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pbq assertion failed");

`endif

[rtl/core/pbq_pkg.sv]
// Package with widths, codes and interface structs of the priority bin queue tracker.
package pbq_pkg;

   localparam int TABLE_BINS = 64;
   localparam int BIN_W      = $clog2(TABLE_BINS);
   localparam int M_W        = BIN_W + 1;
   localparam int PRIO_W     = 16;
   localparam int COUNT_W    = 16;
   localparam int OP_W       = 2;
   localparam int IDX_W      = 6;
   localparam int CFG_W      = 7;
   localparam int MOD_STEPS  = PRIO_W / 2;
   localparam int MOD_CNT_W  = $clog2(MOD_STEPS);

   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(64);

   typedef enum logic [OP_W-1:0] {
      OP_ADD      = 2'd0,
      OP_REMOVE   = 2'd1,
      OP_PEEK     = 2'd2,
      OP_RESERVED = 2'd3
   } op_type;

   typedef struct packed {
      logic              start;
      logic [PRIO_W-1:0] dividend;
      logic [M_W-1:0]    divisor;
   } mod_req_type;

   typedef struct packed {
      logic             done;
      logic [BIN_W-1:0] rem;
   } mod_rsp_type;

   typedef struct packed {
      logic             en;
      logic [BIN_W-1:0] addr;
   } store_rd_type;

   typedef struct packed {
      logic               en;
      logic               clear;
      logic [BIN_W-1:0]   addr;
      logic [COUNT_W-1:0] count;
      logic [PRIO_W-1:0]  prio;
   } store_wr_type;

   typedef struct packed {
      logic               valid;
      logic [COUNT_W-1:0] count;
      logic [PRIO_W-1:0]  prio;
   } store_rd_data_type;

endpackage

[rtl/core/pbq_channels.sv]
// Request and response channel interfaces of the priority bin queue tracker.
interface pbq_req_if;
   import pbq_pkg::*;

   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [PRIO_W-1:0] priority_req;
   logic [IDX_W-1:0]  bin_index;

   modport source (output valid, operation, priority_req, bin_index, input ready);
   modport sink   (input valid, operation, priority_req, bin_index, output ready);
endinterface

interface pbq_rsp_if;
   import pbq_pkg::*;

   logic               valid;
   logic               ready;
   logic               status;
   logic               top_valid;
   logic [IDX_W-1:0]   top_bin;
   logic [COUNT_W-1:0] top_count;
   logic [PRIO_W-1:0]  highest_priority;

   modport source (output valid, status, top_valid, top_bin, top_count, highest_priority,
                   input ready);
   modport sink   (input valid, status, top_valid, top_bin, top_count, highest_priority,
                   output ready);
endinterface

[rtl/core/pbq_mod_unit.sv]
// Iterative remainder unit: priority modulo bin count, two bits per cycle.
`include "assert_macros.svh"

module pbq_mod_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  pbq_pkg::mod_req_type mod_req,
   output pbq_pkg::mod_rsp_type mod_rsp
);
   import pbq_pkg::*;

   logic                 busy_ff,  busy_in;
   logic                 done_ff,  done_in;
   logic [MOD_CNT_W-1:0] cnt_ff,   cnt_in;
   logic [PRIO_W-1:0]    dvd_ff,   dvd_in;
   logic [M_W-1:0]       div_ff,   div_in;
   logic [BIN_W-1:0]     rem_ff,   rem_in;
   logic [M_W-1:0]       trial_a;
   logic [M_W-1:0]       trial_b;
   logic [BIN_W-1:0]     rem_a;

   always_comb begin
      trial_a = {rem_ff, dvd_ff[PRIO_W-1]};
      if (trial_a >= div_ff) begin
         trial_a = trial_a - div_ff;
      end
      rem_a   = BIN_W'(trial_a);
      trial_b = {rem_a, dvd_ff[PRIO_W-2]};
      if (trial_b >= div_ff) begin
         trial_b = trial_b - div_ff;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      if (mod_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = mod_req.dividend;
         div_in  = mod_req.divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = BIN_W'(trial_b);
         dvd_in = {dvd_ff[PRIO_W-3:0], 2'b00};
         cnt_in = cnt_ff + MOD_CNT_W'(1);
         if (cnt_ff == MOD_CNT_W'(MOD_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign mod_rsp.done = done_ff;
   assign mod_rsp.rem  = rem_ff;

   `PBQ_ASSERT_IMPL(a_rem_below_divisor, clock, reset, done_ff, M_W'(rem_ff) < div_ff)
   `PBQ_ASSERT_NEXT(a_done_ends_busy, clock, reset, done_in, !busy_ff)

endmodule

[rtl/core/pbq_bin_store.sv]
// Bin table: count and first priority per bin in a memory, occupancy in flip-flops.
module pbq_bin_store (
   input  logic                       clock,
   input  logic                       reset,
   input  pbq_pkg::store_rd_type      rd_req,
   input  pbq_pkg::store_wr_type      wr_req,
   input  logic [pbq_pkg::BIN_W-1:0]  probe_addr,
   output logic                       probe_valid,
   output pbq_pkg::store_rd_data_type rd_data
);
   import pbq_pkg::*;

   logic [COUNT_W+PRIO_W-1:0] mem [TABLE_BINS];
   logic [TABLE_BINS-1:0]     vld_ff;
   logic [COUNT_W+PRIO_W-1:0] rd_word_ff;
   logic                      rd_vld_ff;

   // A bin whose valid bit is low reads as an empty bin.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_req.en) begin
         vld_ff[wr_req.addr] <= !wr_req.clear;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_req.en && !wr_req.clear) begin
         mem[wr_req.addr] <= {wr_req.count, wr_req.prio};
      end
   end

   always_ff @(posedge clock) begin
      if (rd_req.en) begin
         rd_word_ff <= mem[rd_req.addr];
         rd_vld_ff  <= vld_ff[rd_req.addr];
      end
   end

   assign probe_valid   = vld_ff[probe_addr];
   assign rd_data.valid = rd_vld_ff;
   assign rd_data.count = rd_vld_ff ? rd_word_ff[COUNT_W+PRIO_W-1:PRIO_W] : '0;
   assign rd_data.prio  = rd_vld_ff ? rd_word_ff[PRIO_W-1:0] : '0;

endmodule

[rtl/core/priority_bin_queue_tracker_core.sv]
// Top level of the priority bin queue tracker: sequencer, registers and output stage.
//
// Usage. Request words arrive on req_chan (valid/ready) and carry an operation
// (add, remove, peek), a priority for add and a bin index for remove. Each request
// word produces exactly one response word on rsp_chan with a status bit, the
// top-valid flag, the top bin, its count and the highest tracked priority, all as
// they stand after the operation. The bin count M is written through csr_wr_en and
// csr_wr_data at any idle time; zero acts as one, values above the table size clamp.
// Throughput. The block works on one word at a time and drops req_chan.ready while
// busy. Every modulo by M runs through one shared remainder unit that retires two
// dividend bits per cycle, and the bin table is a memory with a registered read port.
// The report runs a modulo and a table read. An add first runs a modulo and a read
// of its own, a remove within the table first reads its bin, and a remove that empties
// one of several occupied bins then runs a modulo and a downward search over at most
// M bins and reads the bin it finds. With no bin occupied the report skips the
// modulo and the read.
// Reset. A synchronous reset clears every per-bin valid flag and the top priority.
// Stalls. The response sits in an output register; the next request word is still
// accepted while it waits, and that word's response holds in the last sequencer step
// until the output register frees up.
`include "assert_macros.svh"

module priority_bin_queue_tracker_core (
   input  logic                        clock,
   input  logic                        reset,
   pbq_req_if.sink                     req_chan,
   pbq_rsp_if.source                   rsp_chan,
   input  logic                        csr_wr_en,
   input  logic [pbq_pkg::CFG_W-1:0]   csr_wr_data
);
   import pbq_pkg::*;

   typedef enum logic [10:0] {
      S_IDLE     = 11'b00000000001,
      S_ADD_MOD  = 11'b00000000010,
      S_ADD_RD   = 11'b00000000100,
      S_REM_RD   = 11'b00000001000,
      S_SRCH_MOD = 11'b00000010000,
      S_SRCH     = 11'b00000100000,
      S_SRCH_RD  = 11'b00001000000,
      S_RPT      = 11'b00010000000,
      S_RPT_MOD  = 11'b00100000000,
      S_RPT_RD   = 11'b01000000000,
      S_OUT      = 11'b10000000000
   } state_type;

   state_type          state_ff,  state_in;
   logic [CFG_W-1:0]   csr_ff;
   op_type             op_ff,     op_in;
   logic [PRIO_W-1:0]  prio_ff,   prio_in;
   logic [BIN_W-1:0]   addr_ff,   addr_in;
   logic [BIN_W-1:0]   steps_ff,  steps_in;
   logic               status_ff, status_in;
   logic [M_W-1:0]     occ_ff,    occ_in;
   logic [PRIO_W-1:0]  top_ff,    top_in;
   logic [COUNT_W-1:0] tcount_ff, tcount_in;

   logic               out_vld_ff, out_vld_in;
   logic               out_status_ff;
   logic               out_tvalid_ff;
   logic [IDX_W-1:0]   out_tbin_ff;
   logic [COUNT_W-1:0] out_tcount_ff;
   logic [PRIO_W-1:0]  out_prio_ff;
   logic               out_load;

   logic [M_W-1:0]     m_eff;
   logic [BIN_W-1:0]   m_last;
   logic               accept;
   logic               out_free;
   logic               mod_wait;
   logic               occ_ok;

   mod_req_type        mod_req;
   mod_rsp_type        mod_rsp;
   store_rd_type       rd_req;
   store_wr_type       wr_req;
   store_rd_data_type  rd_data;
   logic               probe_valid;

   // Effective bin count, clamped to one through the table size.
   always_comb begin
      if (csr_ff == '0) begin
         m_eff = M_W'(1);
      end else if (int'(csr_ff) > TABLE_BINS) begin
         m_eff = M_W'(TABLE_BINS);
      end else begin
         m_eff = M_W'(csr_ff);
      end
      m_last = BIN_W'(m_eff - M_W'(1));
   end

   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !out_vld_ff || rsp_chan.ready;

   pbq_mod_unit u_mod (
      .clock   (clock),
      .reset   (reset),
      .mod_req (mod_req),
      .mod_rsp (mod_rsp)
   );

   pbq_bin_store u_store (
      .clock       (clock),
      .reset       (reset),
      .rd_req      (rd_req),
      .wr_req      (wr_req),
      .probe_addr  (addr_ff),
      .probe_valid (probe_valid),
      .rd_data     (rd_data)
   );

   // Sequencer. addr_ff names the bin of interest in every phase: the target bin
   // of an add or remove, then the search cursor, then the reported top bin.
   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      prio_in   = prio_ff;
      addr_in   = addr_ff;
      steps_in  = steps_ff;
      status_in = status_ff;
      occ_in    = occ_ff;
      top_in    = top_ff;
      tcount_in = tcount_ff;
      out_load  = 1'b0;

      mod_req.start    = 1'b0;
      mod_req.dividend = top_ff;
      mod_req.divisor  = m_eff;
      rd_req.en        = 1'b0;
      rd_req.addr      = addr_ff;
      wr_req.en        = 1'b0;
      wr_req.clear     = 1'b0;
      wr_req.addr      = addr_ff;
      wr_req.count     = rd_data.count;
      wr_req.prio      = rd_data.prio;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in     = op_type'(req_chan.operation);
               prio_in   = req_chan.priority_req;
               addr_in   = BIN_W'(req_chan.bin_index);
               status_in = 1'b0;
               case (op_type'(req_chan.operation))
                  OP_ADD: begin
                     mod_req.start    = 1'b1;
                     mod_req.dividend = req_chan.priority_req;
                     state_in         = S_ADD_MOD;
                  end
                  OP_REMOVE: begin
                     if (int'(req_chan.bin_index) >= TABLE_BINS) begin
                        status_in = 1'b1;
                        state_in  = S_RPT;
                     end else begin
                        rd_req.en   = 1'b1;
                        rd_req.addr = BIN_W'(req_chan.bin_index);
                        state_in    = S_REM_RD;
                     end
                  end
                  OP_PEEK: begin
                     state_in = S_RPT;
                  end
                  default: begin
                     status_in = 1'b1;
                     state_in  = S_RPT;
                  end
               endcase
            end
         end
         S_ADD_MOD: begin
            if (mod_rsp.done) begin
               addr_in     = mod_rsp.rem;
               rd_req.en   = 1'b1;
               rd_req.addr = mod_rsp.rem;
               state_in    = S_ADD_RD;
            end
         end
         S_ADD_RD: begin
            if (rd_data.count == '1) begin
               status_in = 1'b1;
            end else begin
               wr_req.en    = 1'b1;
               wr_req.count = rd_data.count + COUNT_W'(1);
               if (rd_data.count == '0) begin
                  wr_req.prio = prio_ff;
                  occ_in      = occ_ff + M_W'(1);
               end
               if (prio_ff > top_ff) begin
                  top_in = prio_ff;
               end
            end
            state_in = S_RPT;
         end
         S_REM_RD: begin
            if (rd_data.count == '0) begin
               status_in = 1'b1;
               state_in  = S_RPT;
            end else if (rd_data.count == COUNT_W'(1)) begin
               // The bin empties: drop it, then look for a new top unless no bin stays occupied.
               wr_req.en    = 1'b1;
               wr_req.clear = 1'b1;
               if (occ_ff > M_W'(1)) begin
                  occ_in        = occ_ff - M_W'(1);
                  mod_req.start = 1'b1;
                  state_in      = S_SRCH_MOD;
               end else begin
                  occ_in   = '0;
                  top_in   = '0;
                  state_in = S_RPT;
               end
            end else begin
               wr_req.en    = 1'b1;
               wr_req.count = rd_data.count - COUNT_W'(1);
               state_in     = S_RPT;
            end
         end
         S_SRCH_MOD: begin
            if (mod_rsp.done) begin
               addr_in  = mod_rsp.rem;
               steps_in = '0;
               state_in = S_SRCH;
            end
         end
         S_SRCH: begin
            // Walk down through bins M-1..0 in a circle, one bin per cycle.
            if (probe_valid) begin
               rd_req.en = 1'b1;
               state_in  = S_SRCH_RD;
            end else if (steps_ff == m_last) begin
               top_in   = '0;
               state_in = S_RPT;
            end else begin
               addr_in  = (addr_ff == '0) ? m_last : addr_ff - BIN_W'(1);
               steps_in = steps_ff + BIN_W'(1);
            end
         end
         S_SRCH_RD: begin
            top_in   = rd_data.prio;
            state_in = S_RPT;
         end
         S_RPT: begin
            if (occ_ff == '0) begin
               addr_in   = '0;
               tcount_in = '0;
               state_in  = S_OUT;
            end else begin
               mod_req.start = 1'b1;
               state_in      = S_RPT_MOD;
            end
         end
         S_RPT_MOD: begin
            if (mod_rsp.done) begin
               addr_in     = mod_rsp.rem;
               rd_req.en   = 1'b1;
               rd_req.addr = mod_rsp.rem;
               state_in    = S_RPT_RD;
            end
         end
         S_RPT_RD: begin
            tcount_in = rd_data.count;
            state_in  = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register; it empties when the receiver takes the word.
   always_comb begin
      out_vld_in = out_vld_ff;
      if (out_load) begin
         out_vld_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         csr_ff     <= CFG_RESET;
         occ_ff     <= '0;
         top_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         occ_ff     <= occ_in;
         top_ff     <= top_in;
         out_vld_ff <= out_vld_in;
         if (csr_wr_en) begin
            csr_ff <= csr_wr_data;
         end
      end
      op_ff     <= op_in;
      prio_ff   <= prio_in;
      addr_ff   <= addr_in;
      steps_ff  <= steps_in;
      status_ff <= status_in;
      tcount_ff <= tcount_in;
      if (out_load) begin
         out_status_ff <= status_ff;
         out_tvalid_ff <= (occ_ff != '0);
         out_tbin_ff   <= IDX_W'(addr_ff);
         out_tcount_ff <= tcount_ff;
         out_prio_ff   <= top_ff;
      end
   end

   assign req_chan.ready            = (state_ff == S_IDLE);
   assign rsp_chan.valid            = out_vld_ff;
   assign rsp_chan.status           = out_status_ff;
   assign rsp_chan.top_valid        = out_tvalid_ff;
   assign rsp_chan.top_bin          = out_tbin_ff;
   assign rsp_chan.top_count        = out_tcount_ff;
   assign rsp_chan.highest_priority = out_prio_ff;

   assign mod_wait = (state_ff == S_ADD_MOD) || (state_ff == S_SRCH_MOD) ||
                     (state_ff == S_RPT_MOD);
   assign occ_ok   = (occ_in != '0) && (occ_in <= M_W'(TABLE_BINS));

   `PBQ_ASSERT_IMPL(a_mod_done_awaited, clock, reset, mod_rsp.done, mod_wait)
   `PBQ_ASSERT_IMPL(a_search_bound, clock, reset, state_ff == S_SRCH, M_W'(steps_ff) < m_eff)
   `PBQ_ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, !req_chan.ready)
   `PBQ_ASSERT_IMPL(a_occ_bound, clock, reset, wr_req.en && !wr_req.clear, occ_ok)

endmodule

[verif/priority_bin_queue_tracker_core_test.sv]
// Self-checking testbench of the priority bin queue tracker core.
import pbq_pkg::*;

// One response word as the block reports it, field by field.
typedef struct packed {
   logic               status;
   logic               top_valid;
   logic [IDX_W-1:0]   top_bin;
   logic [COUNT_W-1:0] top_count;
   logic [PRIO_W-1:0]  highest_priority;
} tracker_result_type;

// Shadow of the bin table plus the responses it says are still owed by the block.
class bin_table_tracker_type;
   logic [COUNT_W-1:0] counts [TABLE_BINS];
   logic [PRIO_W-1:0]  first_prio [TABLE_BINS];
   int unsigned        occupied;
   logic [PRIO_W-1:0]  top_prio;
   logic [CFG_W-1:0]   bins_reg;
   tracker_result_type owed_responses [$];
   int unsigned        mismatches;
   int unsigned        checked;
   int unsigned        error_words;

   function new();
      for (int i = 0; i < TABLE_BINS; i++) begin
         counts[i] = '0;
         first_prio[i] = '0;
      end
      occupied = 0;
      top_prio = '0;
      bins_reg = CFG_RESET;
      mismatches = 0;
      checked = 0;
      error_words = 0;
   endfunction

   function void set_bins(logic [CFG_W-1:0] value);
      bins_reg = value;
   endfunction

   // Zero acts as one bin and anything above the table size clamps to it.
   function int unsigned modulus();
      int unsigned m;
      m = 32'(bins_reg);
      if (m < 1) m = 1;
      if (m > TABLE_BINS) m = TABLE_BINS;
      return m;
   endfunction

   function int unsigned pending();
      return owed_responses.size();
   endfunction

   // A random occupied bin anywhere in the table, or -1 when all are empty.
   function int pick_occupied();
      int busy [$];
      for (int i = 0; i < TABLE_BINS; i++)
         if (counts[i] != 0) busy.push_back(i);
      if (busy.size() == 0) return -1;
      return busy[$urandom_range(0, busy.size() - 1)];
   endfunction

   function void note_request(op_type op, logic [PRIO_W-1:0] prio, logic [IDX_W-1:0] idx);
      int unsigned        m;
      int unsigned        b;
      int unsigned        probe;
      bit                 found;
      tracker_result_type r;
      m = modulus();
      r = '0;
      case (op)
         OP_ADD: begin
            b = prio % m;
            if (counts[b] == '1) begin
               r.status = 1'b1;
            end else begin
               if (counts[b] == 0) begin
                  first_prio[b] = prio;
                  occupied++;
               end
               counts[b]++;
               if (prio > top_prio) top_prio = prio;
            end
         end
         OP_REMOVE: begin
            if (counts[idx] == 0) begin
               r.status = 1'b1;
            end else begin
               counts[idx]--;
               if (counts[idx] == 0) begin
                  if (occupied > 0) occupied--;
                  if (occupied == 0) begin
                     top_prio = '0;
                  end else begin
                     // Circular downward search over bins 0..M-1 only.
                     probe = top_prio % m;
                     found = 1'b0;
                     for (int unsigned s = 0; s < m && !found; s++) begin
                        if (counts[probe] != 0) begin
                           top_prio = first_prio[probe];
                           found = 1'b1;
                        end else begin
                           probe = (probe + m - 1) % m;
                        end
                     end
                     if (!found) top_prio = '0;
                  end
                  first_prio[idx] = '0;
               end
            end
         end
         OP_RESERVED: r.status = 1'b1;
         default: ;
      endcase
      r.top_valid = (occupied > 0);
      if (r.top_valid) begin
         r.top_bin = IDX_W'(top_prio % m);
         r.top_count = counts[top_prio % m];
      end
      r.highest_priority = top_prio;
      if (r.status) error_words++;
      owed_responses.push_back(r);
   endfunction

   function void check_response(tracker_result_type got);
      tracker_result_type want;
      bit                 bad;
      checked++;
      if (owed_responses.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("Response word with nothing owed: st=%0d tv=%0d bin=%0d cnt=%0d hp=%0d",
                     got.status, got.top_valid, got.top_bin, got.top_count,
                     got.highest_priority);
         return;
      end
      want = owed_responses.pop_front();
      bad = (got.status != want.status) || (got.top_valid != want.top_valid) ||
            (got.top_bin != want.top_bin) || (got.top_count != want.top_count) ||
            (got.highest_priority != want.highest_priority);
      if (bad) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("Mismatch on response %0d:", checked);
            $display("  expected st=%0d tv=%0d bin=%0d cnt=%0d hp=%0d", want.status,
                     want.top_valid, want.top_bin, want.top_count, want.highest_priority);
            $display("  actual   st=%0d tv=%0d bin=%0d cnt=%0d hp=%0d", got.status,
                     got.top_valid, got.top_bin, got.top_count, got.highest_priority);
         end
      end
   endfunction
endclass

module priority_bin_queue_tracker_core_test;

   // The receiver holds off this long once, so that the block fills and stalls its input.
   localparam int HOLD_CYCLES = 400;
   // A correct run never goes this long without a word moving on either channel:
   // the hold-off plus the slowest remove with a full search is well below it.
   localparam int STALL_LIMIT = 3000;
   localparam int PHASE_WORDS = 40;
   // After the last response the block is idle; the tail still catches any extra response word.
   localparam int TAIL_CYCLES = 100;

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [CFG_W-1:0] csr_wr_data;

   pbq_req_if req_chan();
   pbq_rsp_if rsp_chan();

   priority_bin_queue_tracker_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   bin_table_tracker_type board;

   int unsigned burst_left;
   int unsigned words_sent;
   int unsigned settings_used;
   int unsigned idle_cycles;
   bit          hold_request;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Request words are noted at the edge that accepts them. The values read here are
   // the ones from before the edge, since everything is driven at the falling edge.
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready) begin
         board.note_request(op_type'(req_chan.operation), req_chan.priority_req,
                            req_chan.bin_index);
         words_sent++;
      end
   end

   always @(posedge clock) begin
      tracker_result_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.status = rsp_chan.status;
         got.top_valid = rsp_chan.top_valid;
         got.top_bin = rsp_chan.top_bin;
         got.top_count = rsp_chan.top_count;
         got.highest_priority = rsp_chan.highest_priority;
         board.check_response(got);
      end
   end

   // The watchdog counts cycles in which no word moves on either channel.
   initial begin
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Timeout: no word moved for %0d cycles, %0d responses still owed",
               STALL_LIMIT, board.pending());
      $display("FAILURE");
      $finish;
   end

   // The receiver runs stretches of one stall pattern at a time, including stretches
   // with no stall at all. On request it holds off for one long stretch.
   initial begin
      int unsigned stretch_left;
      int unsigned pattern;
      int unsigned phase_cnt;
      rsp_chan.ready = 1'b0;
      stretch_left = 0;
      pattern = 0;
      phase_cnt = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_request = 1'b0;
         end else begin
            if (stretch_left == 0) begin
               stretch_left = $urandom_range(10, 80);
               pattern = $urandom_range(0, 3);
            end
            stretch_left--;
            phase_cnt++;
            case (pattern)
               0: rsp_chan.ready <= 1'b1;
               1: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
               2: rsp_chan.ready <= 1'($urandom_range(0, 1));
               default: rsp_chan.ready <= (phase_cnt % 5 != 0);
            endcase
         end
      end
   end

   // Offers one request word. It is called at a falling edge and returns at the falling
   // edge after the word was accepted, so the board already holds its effect by then.
   // Valid stays high across back-to-back words; a gap lowers it first.
   task automatic send_word(op_type op, logic [PRIO_W-1:0] prio, logic [IDX_W-1:0] idx);
      int unsigned gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
      end
      burst_left--;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.operation <= op;
      req_chan.priority_req <= prio;
      req_chan.bin_index <= idx;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   // Lowers valid and waits at falling edges until every owed response has arrived.
   // One word always gives one response, so the block is idle after that.
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
   endtask

   task automatic write_bins(logic [CFG_W-1:0] value);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      board.set_bins(value);
      settings_used++;
   endtask

   // Removes entries until every bin in the table is empty, also the ones above M.
   task automatic drain_table();
      int bin;
      bin = board.pick_occupied();
      while (bin >= 0) begin
         send_word(OP_REMOVE, PRIO_W'($urandom_range(0, 65535)), IDX_W'(bin));
         bin = board.pick_occupied();
      end
   endtask

   // A random word. Most removes target occupied bins so that bins really empty and
   // the downward search runs; half the add priorities stay below four times M.
   task automatic random_word();
      int unsigned sel;
      int unsigned m;
      int          bin;
      logic [PRIO_W-1:0] prio;
      sel = $urandom_range(0, 99);
      m = board.modulus();
      if (sel < 45) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: prio = PRIO_W'($urandom_range(0, 4 * m - 1));
            5, 6:          prio = PRIO_W'($urandom_range(65472, 65535));
            default:       prio = PRIO_W'($urandom_range(0, 65535));
         endcase
         send_word(OP_ADD, prio, IDX_W'($urandom_range(0, 63)));
      end else if (sel < 80) begin
         bin = board.pick_occupied();
         if (bin < 0 || $urandom_range(0, 6) == 0) bin = int'($urandom_range(0, 63));
         send_word(OP_REMOVE, PRIO_W'($urandom_range(0, 65535)), IDX_W'(bin));
      end else if (sel < 95) begin
         send_word(OP_PEEK, PRIO_W'($urandom_range(0, 65535)),
                   IDX_W'($urandom_range(0, 63)));
      end else begin
         send_word(OP_RESERVED, PRIO_W'($urandom_range(0, 65535)),
                   IDX_W'($urandom_range(0, 63)));
      end
   endtask

   initial begin
      logic [CFG_W-1:0] settings [11];
      board = new();
      burst_left = 0;
      words_sent = 0;
      settings_used = 0;
      hold_request = 1'b0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_chan.valid = 1'b0;
      req_chan.operation = OP_PEEK;
      req_chan.priority_req = '0;
      req_chan.bin_index = '0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part at the reset setting of 64 bins: an empty table, the error
      // cases, both ends of the priority range and a search that lands on bin zero.
      send_word(OP_PEEK, 16'h0000, 6'd0);
      send_word(OP_REMOVE, 16'h0000, 6'd0);
      send_word(OP_RESERVED, 16'hFFFF, 6'd63);
      send_word(OP_ADD, 16'hFFFF, 6'd0);
      send_word(OP_ADD, 16'h0000, 6'd0);
      send_word(OP_ADD, 16'd64, 6'd0);
      send_word(OP_ADD, 16'h7FFF, 6'd0);
      send_word(OP_PEEK, 16'h0000, 6'd0);
      send_word(OP_REMOVE, 16'h0000, 6'd63);
      send_word(OP_REMOVE, 16'h0000, 6'd63);
      send_word(OP_REMOVE, 16'h0000, 6'd0);
      send_word(OP_REMOVE, 16'h0000, 6'd0);
      send_word(OP_ADD, 16'd50, 6'd0);
      send_word(OP_ADD, 16'd3, 6'd0);
      send_word(OP_REMOVE, 16'h0000, 6'd63);

      // Shrinking to 8 bins leaves bin 50 occupied but out of reach: emptying bin 3
      // must drop the highest priority to zero while top_valid stays high.
      write_bins(CFG_W'(8));
      send_word(OP_REMOVE, 16'h0000, 6'd3);
      send_word(OP_PEEK, 16'h0000, 6'd0);
      send_word(OP_REMOVE, 16'h0000, 6'd50);

      // A setting of zero acts as one bin, so both adds share bin zero.
      write_bins(CFG_W'(0));
      send_word(OP_ADD, 16'd5, 6'd0);
      send_word(OP_ADD, 16'd9, 6'd0);
      send_word(OP_REMOVE, 16'h0000, 6'd0);
      send_word(OP_REMOVE, 16'h0000, 6'd0);

      // The all-ones setting clamps to the table size.
      write_bins(CFG_W'(127));
      send_word(OP_ADD, 16'd100, 6'd0);
      send_word(OP_REMOVE, 16'h0000, 6'd36);
      send_word(OP_PEEK, 16'h0000, 6'd0);

      // Random part. Every other phase ends with the table drained; the others carry
      // their entries into the next setting, so the modulus changes while occupied.
      settings = '{7'd64, 7'd1, 7'd2, 7'd13, 7'd127, 7'd40, 7'd0, 7'd63, 7'd65, 7'd5,
                   7'd0};
      settings[10] = CFG_W'($urandom_range(0, 127));
      for (int p = 0; p < 11; p++) begin
         write_bins(settings[p]);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            // In the third phase the receiver holds off while words keep coming.
            if (p == 2 && n == 10) hold_request = 1'b1;
            random_word();
         end
         if (p % 2 == 1) drain_table();
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Run covered %0d request words under %0d bin settings, %0d responses checked,",
               words_sent, settings_used, board.checked);
      $display("%0d of them error words, with one %0d-cycle receiver hold-off.",
               board.error_words, HOLD_CYCLES);
      if (board.pending() != 0)
         $display("%0d expected responses never arrived", board.pending());
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatched responses", board.mismatches);
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/pbq_pkg.sv
rtl/core/pbq_channels.sv
rtl/core/pbq_mod_unit.sv
rtl/core/pbq_bin_store.sv
rtl/core/priority_bin_queue_tracker_core.sv
verif/priority_bin_queue_tracker_core_test.sv
